@@ hdl/stack_queue_deque_engine_defines.svh @@
`ifndef STACK_QUEUE_DEQUE_ENGINE_DEFINES_SVH
`define STACK_QUEUE_DEQUE_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SQDE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqde assertion failed");

// Check that cons holds in the cycle after ante.
`define SQDE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqde assertion failed");

`endif

@@ hdl/sqde_pkg.sv @@
`default_nettype none

package sqde_pkg;

   // Store geometry
   localparam int DEPTH       = 32;
   localparam int MAX_RESULTS = 32;
   localparam int DATA_W      = 32;
   localparam int INDEX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int RESULT_W    = $clog2(MAX_RESULTS + 1);
   localparam int CMP_W       = (COUNT_W > RESULT_W) ? COUNT_W : RESULT_W;

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   // Request codes
   typedef enum logic [2:0] {
      REQ_PUSH  = 3'd0,
      REQ_POP   = 3'd1,
      REQ_PEEK  = 3'd2,
      REQ_SWAP  = 3'd3,
      REQ_PRINT = 3'd4
   } req_code_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_SHORT = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEEK_WAIT,
      ST_SWAP_RD,
      ST_SWAP_WRT,
      ST_SWAP_WRB,
      ST_PRINT
   } state_type;

   // Ring index one slot up
   function automatic logic [INDEX_W-1:0] step_up(input logic [INDEX_W-1:0] x);
      step_up = (x == LAST_INDEX) ? '0 : INDEX_W'(x + 1'b1);
   endfunction

   // Ring index one slot down
   function automatic logic [INDEX_W-1:0] step_down(input logic [INDEX_W-1:0] x);
      step_down = (x == '0) ? LAST_INDEX : INDEX_W'(x - 1'b1);
   endfunction

endpackage

`default_nettype wire

@@ hdl/sqde_ram.sv @@
`default_nettype none

module sqde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/stack_queue_deque_engine.sv @@
// Double-ended stack/queue of signed 32-bit entries held in one single-port-per-
// direction RAM (one read and one write per cycle, registered read output).
// A request is taken when start is high and busy is low; every result appears
// on the rsp_ ports for exactly one cycle with rsp_strobe high, and the
// receiver cannot stall it, so it must take each result as it comes. Results
// come in the cycle after the cycle that produces them. Push, pop, full, empty
// and short errors answer from the idle state; peek does one RAM read; swap
// does two reads and two writes through the one write port; print-all does one
// RAM read per emitted entry and emits the entries from top to bottom,
// at most 32 entries. Unused request codes are taken and give no result.
// The queue_mode register is written through the csr_ channel, which is
// always ready; write it only while the block is idle.
`default_nettype none
`include "stack_queue_deque_engine_defines.svh"

module stack_queue_deque_engine
   import sqde_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [2:0]               req_type,
   input  wire logic signed [DATA_W-1:0] req_push_value,
   output logic                          rsp_strobe,
   output logic signed [DATA_W-1:0]      rsp_value,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_queue_mode
);

   state_type state_ff, state_in;

   logic [INDEX_W-1:0]  top_ff, top_in;
   logic [INDEX_W-1:0]  bottom_ff, bottom_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                mode_ff;
   logic [INDEX_W-1:0]  pos_ff, pos_in;
   logic [RESULT_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0]   tmp_ff, tmp_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                is_empty;
   logic                is_full;
   logic                has_two;
   logic [CMP_W-1:0]    print_wide;
   logic [RESULT_W-1:0] print_n;

   logic                mem_wr_en;
   logic [INDEX_W-1:0]  mem_wr_addr;
   logic [DATA_W-1:0]   mem_wr_data;
   logic                mem_rd_en;
   logic [INDEX_W-1:0]  mem_rd_addr;
   logic [DATA_W-1:0]   mem_rd_data;

   // Entry store
   sqde_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Decode handshake and fill level
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff >= FULL_COUNT);
   assign has_two    = (count_ff >= COUNT_W'(2));
   assign print_wide = CMP_W'(count_ff);
   assign print_n    = (print_wide > CMP_W'(MAX_RESULTS)) ? RESULT_W'(MAX_RESULTS)
                                                          : RESULT_W'(print_wide);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_PEEK:  if (!is_empty) state_in = ST_PEEK_WAIT;
                  REQ_SWAP:  if (has_two)   state_in = ST_SWAP_RD;
                  REQ_PRINT: if (!is_empty) state_in = ST_PRINT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PEEK_WAIT: state_in = ST_IDLE;
         ST_SWAP_RD:   state_in = ST_SWAP_WRT;
         ST_SWAP_WRT:  state_in = ST_SWAP_WRB;
         ST_SWAP_WRB:  state_in = ST_IDLE;
         ST_PRINT: begin
            if (rem_ff == RESULT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory access and results
   always_comb begin
      top_in        = top_ff;
      bottom_in     = bottom_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      tmp_in        = tmp_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STAT_OK;
      rsp_last_in   = 1'b1;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = top_ff;
      mem_wr_data   = req_push_value;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = top_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = COUNT_W'(count_ff + 1'b1);
                        if (is_empty) begin
                           bottom_in   = top_ff;
                           mem_wr_addr = top_ff;
                        end else if (!mode_ff) begin
                           top_in      = step_up(top_ff);
                           mem_wr_addr = step_up(top_ff);
                        end else begin
                           bottom_in   = step_down(bottom_ff);
                           mem_wr_addr = step_down(bottom_ff);
                        end
                     end
                  end
                  REQ_POP: begin
                     rsp_strobe_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        count_in = COUNT_W'(count_ff - 1'b1);
                        if (count_ff == COUNT_W'(1)) begin
                           bottom_in = top_ff;
                        end else begin
                           top_in = step_down(top_ff);
                        end
                     end
                  end
                  REQ_PEEK: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                     end
                  end
                  REQ_SWAP: begin
                     if (!has_two) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_SHORT;
                     end else begin
                        mem_rd_en = 1'b1;
                        pos_in    = step_down(top_ff);
                     end
                  end
                  REQ_PRINT: begin
                     if (!is_empty) begin
                        mem_rd_en = 1'b1;
                        pos_in    = step_down(top_ff);
                        rem_in    = print_n;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_PEEK_WAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = mem_rd_data;
         end
         ST_SWAP_RD: begin
            // hold the top entry, fetch the one below
            tmp_in      = mem_rd_data;
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_ff;
         end
         ST_SWAP_WRT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = top_ff;
            mem_wr_data = mem_rd_data;
         end
         ST_SWAP_WRB: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = pos_ff;
            mem_wr_data   = tmp_ff;
            rsp_strobe_in = 1'b1;
         end
         ST_PRINT: begin
            // emit current entry, advance toward the bottom
            rsp_strobe_in = 1'b1;
            rsp_value_in  = mem_rd_data;
            rsp_last_in   = (rem_ff == RESULT_W'(1));
            if (rem_ff != RESULT_W'(1)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = pos_ff;
               pos_in      = step_down(pos_ff);
               rem_in      = RESULT_W'(rem_ff - 1'b1);
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         top_ff        <= '0;
         bottom_ff     <= '0;
         count_ff      <= '0;
         mode_ff       <= 1'b0;
         rem_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         bottom_ff     <= bottom_in;
         count_ff      <= count_in;
         rem_ff        <= rem_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_queue_mode;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      tmp_ff        <= tmp_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // Checks
   `SQDE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `SQDE_ASSERT_IMP(a_empty_ends_meet, clock, reset, count_ff == '0, top_ff == bottom_ff)
   `SQDE_ASSERT_IMP(a_mid_print, clock, reset, rsp_strobe_ff && !rsp_last_ff,
                    state_ff == ST_PRINT)
   `SQDE_ASSERT_NXT(a_busy_count_hold, clock, reset, state_ff != ST_IDLE, $stable(count_ff))

endmodule

`default_nettype wire
